### hdl/pbpd_pkg.sv
// Shared types, constants and helper functions of the PackBits plane decoder.
package pbpd_pkg;

   // Parameter defaults
   localparam int MAX_DIMENSION_DEF = 4096;
   localparam int MAX_CHANNELS_DEF  = 24;

   // Register widths and reset values
   localparam int   CSR_INDEX_W      = 2;
   localparam int   CSR_DATA_W       = 13;
   localparam int   DIM_REG_W        = 13;
   localparam int   CHAN_REG_W       = 5;
   localparam int   RESET_WIDTH      = 1;
   localparam int   RESET_HEIGHT     = 1;
   localparam int   RESET_CHANNELS   = 3;
   localparam logic RESET_COMPRESSED = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH   = 2'd0,
      CSR_IMAGE_HEIGHT  = 2'd1,
      CSR_CHANNEL_COUNT = 2'd2,
      CSR_COMPRESSED    = 2'd3
   } csr_index_type;

   // Stream field widths
   localparam int DATA_W        = 8;
   localparam int PIXEL_INDEX_W = 24;
   localparam int LANE_W        = 2;
   localparam int RUN_LEN_W     = 8;
   localparam int RSP_DATA_W    = 48;
   localparam int RSP_PAD_W     = RSP_DATA_W - PIXEL_INDEX_W - LANE_W - DATA_W - RUN_LEN_W;

   // Byte queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   // Plane slots: slot number 4 means no plane is left
   localparam int             PLANE_SLOTS = 4;
   localparam int             PLANE_W     = 3;
   localparam logic [PLANE_W-1:0] PLANE_NONE  = 3'd4;
   localparam logic [PLANE_W-1:0] PLANE_FIRST_DEF = 3'd0;

   // PackBits header codes
   localparam logic [DATA_W-1:0] HDR_NOP  = 8'd128;
   localparam logic [DATA_W-1:0] RUN_XOR  = 8'hFF;
   localparam logic [DATA_W-1:0] RUN_BIAS = 8'd2;

   typedef enum logic [2:0] {
      PH_HEADER  = 3'b001,
      PH_LITERAL = 3'b010,
      PH_RUN     = 3'b100
   } phase_type;

   typedef struct packed {
      logic                   restart;
      logic                   compressed;
      logic [PLANE_SLOTS-1:0] plane_mask;
   } back_cfg_type;

   // Byte lane of each plane slot: 2, 1, 0, 3
   function automatic logic [LANE_W-1:0] lane_of(input logic [1:0] slot);
      logic [LANE_W-1:0] lane;
      unique case (slot)
         2'd0: lane = 2'd2;
         2'd1: lane = 2'd1;
         2'd2: lane = 2'd0;
         2'd3: lane = 2'd3;
         default: lane = 2'd0;
      endcase
      return lane;
   endfunction

   // First enabled slot at or after from, PLANE_NONE when there is none
   function automatic logic [PLANE_W-1:0] find_plane(input logic [PLANE_W-1:0] from,
                                                     input logic [PLANE_SLOTS-1:0] mask);
      logic [PLANE_W-1:0] sel;
      logic               found;
      sel   = PLANE_NONE;
      found = 1'b0;
      for (int i = 0; i < PLANE_SLOTS; i++) begin
         if (!found && (PLANE_W'(i) >= from) && mask[i]) begin
            sel   = PLANE_W'(i);
            found = 1'b1;
         end
      end
      return sel;
   endfunction

endpackage

### hdl/pbpd_fifo.sv
// Short byte queue between the front classifier and the back decoder.
module pbpd_fifo (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  logic [pbpd_pkg::DATA_W-1:0] push_data,
   input  logic                        pop,
   output logic                        full,
   output logic                        head_valid,
   output logic [pbpd_pkg::DATA_W-1:0] head_data
);

   logic [pbpd_pkg::DATA_W-1:0]      mem_ff [pbpd_pkg::QUEUE_DEPTH];
   logic [pbpd_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [pbpd_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [pbpd_pkg::QUEUE_CNT_W-1:0] cnt_ff, cnt_in;
   logic                             do_push;
   logic                             do_pop;

   assign full       = (cnt_ff == pbpd_pkg::QUEUE_CNT_W'(pbpd_pkg::QUEUE_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store the pushed byte
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### hdl/pbpd_front.sv
// Front end: accepts stream bytes, drops scan-line count bytes, queues the rest.
module pbpd_front #(
   parameter int SKIP_W = 18
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        restart,
   input  logic                        compressed,
   input  logic [SKIP_W-1:0]           skip_len,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [pbpd_pkg::DATA_W-1:0] req_tdata,
   input  logic                        q_full,
   output logic                        q_push,
   output logic [pbpd_pkg::DATA_W-1:0] q_data
);

   logic              skip_active_ff, skip_active_in;
   logic [SKIP_W-1:0] skip_cnt_ff, skip_cnt_in;
   logic [SKIP_W-1:0] skip_cnt_inc;
   logic              skipping;
   logic              accept;

   assign req_tready   = !q_full;
   assign accept       = req_tvalid && req_tready;
   assign skipping     = skip_active_ff && compressed;
   assign skip_cnt_inc = skip_cnt_ff + 1'b1;
   assign q_push       = accept && !skipping;
   assign q_data       = req_tdata;

   // Count skipped bytes; the last one ends the skip phase
   always_comb begin
      skip_active_in = skip_active_ff;
      skip_cnt_in    = skip_cnt_ff;
      if (restart) begin
         skip_active_in = 1'b1;
         skip_cnt_in    = '0;
      end else if (accept && skipping) begin
         skip_cnt_in = skip_cnt_inc;
         if (skip_cnt_inc >= skip_len) begin
            skip_active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_active_ff <= 1'b1;
         skip_cnt_ff    <= '0;
      end else begin
         skip_active_ff <= skip_active_in;
         skip_cnt_ff    <= skip_cnt_in;
      end
   end

endmodule

### hdl/pbpd_back.sv
// Back end: decodes headers, literals, runs and raw bytes into run writes.
module pbpd_back #(
   parameter int POS_W = 25
) (
   input  logic                            clock,
   input  logic                            reset,
   input  pbpd_pkg::back_cfg_type          cfg,
   input  logic [POS_W-1:0]                total,
   input  logic                            head_valid,
   input  logic [pbpd_pkg::DATA_W-1:0]     head_data,
   output logic                            pop,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // pixel_index[23:0], byte_lane[25:24], pixel_value[33:26], run_length[41:34]
   output logic [pbpd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // run_clipped
   output logic                            rsp_tuser,
   output logic                            rsp_tlast
);

   localparam int EXT_W = POS_W + 1;

   logic [pbpd_pkg::PLANE_W-1:0]       plane_ff, plane_in;
   logic [POS_W-1:0]                   pos_ff, pos_in;
   logic [pbpd_pkg::RUN_LEN_W-1:0]     lit_ff, lit_in;
   pbpd_pkg::phase_type                phase_ff, phase_in;

   logic                               out_valid_ff, out_valid_in;
   logic [pbpd_pkg::PIXEL_INDEX_W-1:0] out_index_ff, out_index_in;
   logic [pbpd_pkg::LANE_W-1:0]        out_lane_ff, out_lane_in;
   logic [pbpd_pkg::DATA_W-1:0]        out_value_ff, out_value_in;
   logic [pbpd_pkg::RUN_LEN_W-1:0]     out_len_ff, out_len_in;
   logic                               out_clip_ff, out_clip_in;
   logic                               out_end_ff, out_end_in;

   logic                               finished;
   logic                               out_free;
   logic [pbpd_pkg::PLANE_W-1:0]       next_plane;
   logic                               last_plane;
   logic [EXT_W-1:0]                   pos_ext, tot_ext, pos_inc, room, lit_ext, run_end;
   logic [EXT_W-1:0]                   pos_after;
   logic                               run_clip;
   logic [pbpd_pkg::RUN_LEN_W-1:0]     run_len;
   logic [pbpd_pkg::RUN_LEN_W-1:0]     lit_dec;
   logic                               fills;
   logic                               pos_lt;
   logic                               emit;
   logic                               advance;
   logic [pbpd_pkg::DATA_W-1:0]        b;

   assign b          = head_data;
   assign finished   = plane_ff[pbpd_pkg::PLANE_W-1];
   assign out_free   = !out_valid_ff || rsp_tready;
   assign pop        = head_valid && out_free;
   assign next_plane = pbpd_pkg::find_plane(plane_ff + 1'b1, cfg.plane_mask);
   assign last_plane = next_plane[pbpd_pkg::PLANE_W-1];

   // Position arithmetic against the plane size
   assign pos_ext  = EXT_W'(pos_ff);
   assign tot_ext  = EXT_W'(total);
   assign pos_inc  = pos_ext + 1'b1;
   assign room     = tot_ext - pos_ext;
   assign lit_ext  = EXT_W'(lit_ff);
   assign run_clip = lit_ext > room;
   assign run_len  = run_clip ? pbpd_pkg::RUN_LEN_W'(room) : lit_ff;
   assign run_end  = pos_ext + EXT_W'(run_len);
   assign fills    = pos_inc >= tot_ext;
   assign pos_lt   = pos_ext < tot_ext;
   assign lit_dec  = (lit_ff == '0) ? '0 : lit_ff - 1'b1;
   assign pos_after = pos_lt ? pos_inc : pos_ext;

   // Decode one byte from the queue
   always_comb begin
      plane_in     = plane_ff;
      pos_in       = pos_ff;
      lit_in       = lit_ff;
      phase_in     = phase_ff;
      emit         = 1'b0;
      advance      = 1'b0;
      out_len_in   = pbpd_pkg::RUN_LEN_W'(1);
      out_clip_in  = 1'b0;
      out_end_in   = 1'b0;

      if (pop && !finished) begin
         if (!cfg.compressed) begin
            // Raw plane: every byte is one pixel
            emit       = 1'b1;
            out_end_in = fills && last_plane;
            pos_in     = POS_W'(pos_inc);
            advance    = fills;
         end else begin
            unique case (phase_ff)
               pbpd_pkg::PH_HEADER: begin
                  if (b < pbpd_pkg::HDR_NOP) begin
                     lit_in   = b + 1'b1;
                     phase_in = pbpd_pkg::PH_LITERAL;
                  end else if (b > pbpd_pkg::HDR_NOP) begin
                     lit_in   = (b ^ pbpd_pkg::RUN_XOR) + pbpd_pkg::RUN_BIAS;
                     phase_in = pbpd_pkg::PH_RUN;
                  end
               end
               pbpd_pkg::PH_LITERAL: begin
                  if (pos_lt) begin
                     emit        = 1'b1;
                     out_clip_in = fills && (lit_ff > pbpd_pkg::RUN_LEN_W'(1));
                     out_end_in  = fills && last_plane;
                  end
                  pos_in = POS_W'(pos_after);
                  lit_in = lit_dec;
                  if (lit_dec == '0) begin
                     if (pos_after >= tot_ext) begin
                        advance = 1'b1;
                     end else begin
                        phase_in = pbpd_pkg::PH_HEADER;
                     end
                  end
               end
               pbpd_pkg::PH_RUN: begin
                  if ((lit_ff == '0) || !pos_lt) begin
                     advance = 1'b1;
                  end else begin
                     emit        = 1'b1;
                     out_len_in  = run_len;
                     out_clip_in = run_clip;
                     out_end_in  = (run_end >= tot_ext) && last_plane;
                     pos_in      = POS_W'(run_end);
                     lit_in      = '0;
                     if (run_end >= tot_ext) begin
                        advance = 1'b1;
                     end else begin
                        phase_in = pbpd_pkg::PH_HEADER;
                     end
                  end
               end
               default: phase_in = pbpd_pkg::PH_HEADER;
            endcase
         end
      end

      // Move to the next decoded plane
      if (advance) begin
         plane_in = next_plane;
         pos_in   = '0;
         lit_in   = '0;
         phase_in = pbpd_pkg::PH_HEADER;
      end

      // Restart from the first plane after a register write
      if (cfg.restart) begin
         plane_in = pbpd_pkg::find_plane('0, cfg.plane_mask);
         pos_in   = '0;
         lit_in   = '0;
         phase_in = pbpd_pkg::PH_HEADER;
      end
   end

   // Load or drain the output register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_index_in = out_index_ff;
      out_lane_in  = out_lane_ff;
      out_value_in = out_value_ff;
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (emit) begin
         out_valid_in = 1'b1;
         out_index_in = pbpd_pkg::PIXEL_INDEX_W'(pos_ff);
         out_lane_in  = pbpd_pkg::lane_of(plane_ff[1:0]);
         out_value_in = b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff     <= pbpd_pkg::PLANE_FIRST_DEF;
         pos_ff       <= '0;
         lit_ff       <= '0;
         phase_ff     <= pbpd_pkg::PH_HEADER;
         out_valid_ff <= 1'b0;
      end else begin
         plane_ff     <= plane_in;
         pos_ff       <= pos_in;
         lit_ff       <= lit_in;
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Hold result payload until transfer
   always_ff @(posedge clock) begin
      out_index_ff <= out_index_in;
      out_lane_ff  <= out_lane_in;
      out_value_ff <= out_value_in;
      if (emit) begin
         out_len_ff  <= out_len_in;
         out_clip_ff <= out_clip_in;
         out_end_ff  <= out_end_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{pbpd_pkg::RSP_PAD_W{1'b0}}, out_len_ff, out_value_ff,
                        out_lane_ff, out_index_ff};
   assign rsp_tuser  = out_clip_ff;
   assign rsp_tlast  = out_end_ff;

endmodule

### hdl/packbits_plane_decoder.sv
// Top level of the PackBits planar image decoder: registers, derived sizes, front, queue, back.
// A byte accepted on req passes through the byte queue and the back output register before its run write shows on rsp.
// Throughput: one byte per cycle while rsp is ready, set by the back decoder handling one queued byte each cycle.
// Skipped count bytes and header bytes give no result.
// Reset (synchronous, active high) loads the register defaults and restarts at the stream start.
// A register write restarts decoding; the derived plane size is registered from the setting registers.
module packbits_plane_decoder #(
   parameter int MAX_DIMENSION = pbpd_pkg::MAX_DIMENSION_DEF,
   parameter int MAX_CHANNELS  = pbpd_pkg::MAX_CHANNELS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // data_byte[7:0]
   input  logic [pbpd_pkg::DATA_W-1:0]      req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // pixel_index[23:0], byte_lane[25:24], pixel_value[33:26], run_length[41:34]
   output logic [pbpd_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // run_clipped
   output logic                             rsp_tuser,
   output logic                             rsp_tlast,
   input  logic                             csr_we,
   input  logic [pbpd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pbpd_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int DIM_W  = $clog2(MAX_DIMENSION + 1);
   localparam int CH_W   = $clog2(MAX_CHANNELS + 1);
   localparam int PROD_W = 2 * DIM_W;
   localparam int HC_W   = DIM_W + CH_W;
   localparam int POS_W  = $clog2(longint'(MAX_DIMENSION) * longint'(MAX_DIMENSION) + 1);
   localparam int SKIP_W = $clog2(MAX_DIMENSION * MAX_CHANNELS * 2 + 1);

   logic [pbpd_pkg::DIM_REG_W-1:0]  width_ff, width_in;
   logic [pbpd_pkg::DIM_REG_W-1:0]  height_ff, height_in;
   logic [pbpd_pkg::CHAN_REG_W-1:0] chan_ff, chan_in;
   logic                            comp_ff, comp_in;
   logic                            restart_ff;
   logic [POS_W-1:0]                total_ff, total_in;
   logic [SKIP_W-1:0]               skip_len_ff, skip_len_in;

   logic [DIM_W-1:0]                w_cl, h_cl;
   logic [CH_W-1:0]                 ch_cl;
   logic [PROD_W-1:0]               area;
   logic [HC_W-1:0]                 hc;
   logic [pbpd_pkg::PLANE_SLOTS-1:0] plane_mask;
   pbpd_pkg::back_cfg_type          back_cfg;

   logic                            q_full, q_push, q_pop, q_head_valid;
   logic [pbpd_pkg::DATA_W-1:0]     q_data, q_head_data;

   // Register writes
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      chan_in   = chan_ff;
      comp_in   = comp_ff;
      if (csr_we) begin
         unique case (pbpd_pkg::csr_index_type'(csr_index))
            pbpd_pkg::CSR_IMAGE_WIDTH:   width_in  = csr_data;
            pbpd_pkg::CSR_IMAGE_HEIGHT:  height_in = csr_data;
            pbpd_pkg::CSR_CHANNEL_COUNT: chan_in   = csr_data[pbpd_pkg::CHAN_REG_W-1:0];
            pbpd_pkg::CSR_COMPRESSED:    comp_in   = csr_data[0];
            default: ;
         endcase
      end
   end

   // Clamp dimensions and channel count
   assign w_cl  = (width_ff == '0) ? DIM_W'(1) :
                  (32'(width_ff) > 32'(MAX_DIMENSION)) ? DIM_W'(MAX_DIMENSION) :
                  DIM_W'(width_ff);
   assign h_cl  = (height_ff == '0) ? DIM_W'(1) :
                  (32'(height_ff) > 32'(MAX_DIMENSION)) ? DIM_W'(MAX_DIMENSION) :
                  DIM_W'(height_ff);
   assign ch_cl = (chan_ff == '0) ? CH_W'(1) :
                  (32'(chan_ff) > 32'(MAX_CHANNELS)) ? CH_W'(MAX_CHANNELS) :
                  CH_W'(chan_ff);

   // Plane size and count-table length
   assign area        = PROD_W'(w_cl) * PROD_W'(h_cl);
   assign hc          = HC_W'(h_cl) * HC_W'(ch_cl);
   assign total_in    = POS_W'(area);
   assign skip_len_in = SKIP_W'({hc, 1'b0});

   // Lanes below the channel count are decoded
   always_comb begin
      for (int i = 0; i < pbpd_pkg::PLANE_SLOTS; i++) begin
         plane_mask[i] = 32'(pbpd_pkg::lane_of(2'(i))) < 32'(ch_cl);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= pbpd_pkg::DIM_REG_W'(pbpd_pkg::RESET_WIDTH);
         height_ff   <= pbpd_pkg::DIM_REG_W'(pbpd_pkg::RESET_HEIGHT);
         chan_ff     <= pbpd_pkg::CHAN_REG_W'(pbpd_pkg::RESET_CHANNELS);
         comp_ff     <= pbpd_pkg::RESET_COMPRESSED;
         restart_ff  <= 1'b0;
         total_ff    <= POS_W'(pbpd_pkg::RESET_WIDTH * pbpd_pkg::RESET_HEIGHT);
         skip_len_ff <= SKIP_W'(pbpd_pkg::RESET_HEIGHT * pbpd_pkg::RESET_CHANNELS * 2);
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         chan_ff     <= chan_in;
         comp_ff     <= comp_in;
         restart_ff  <= csr_we;
         total_ff    <= total_in;
         skip_len_ff <= skip_len_in;
      end
   end

   assign back_cfg.restart    = restart_ff;
   assign back_cfg.compressed = comp_ff;
   assign back_cfg.plane_mask = plane_mask;

   pbpd_front #(
      .SKIP_W (SKIP_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .restart    (csr_we),
      .compressed (comp_ff),
      .skip_len   (skip_len_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_data     (q_data)
   );

   pbpd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_data),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_head_valid),
      .head_data  (q_head_data)
   );

   pbpd_back #(
      .POS_W (POS_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (back_cfg),
      .total      (total_ff),
      .head_valid (q_head_valid),
      .head_data  (q_head_data),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### bench/testbench.sv
// Self-checking testbench of the PackBits plane decoder: directed table, then random planes.
`timescale 1ns / 100ps

module testbench;

   localparam int HALF_PERIOD    = 5;
   localparam int RESET_CYCLES   = 7;
   // Cycles to let queued count and header bytes pass the block before a register write
   localparam int DRAIN_CYCLES   = 16;
   localparam int HOLD_CYCLES    = 200;
   localparam int HOLD_PHASE     = 2;
   // Least number of bytes of all random phases together; the directed table comes on top
   localparam int RANDOM_ITEMS   = 400;
   localparam int EXTREME_PHASES = 5;
   // The tall image only shows the start of its long count-table skip
   localparam int LONG_SKIP_PHASE = 1;
   localparam int LONG_SKIP_BYTES = 40;
   localparam int MAX_DIM        = 4096;
   localparam int MAX_CH         = 24;
   localparam int TIMEOUT_NS     = 5_000_000;

   // Byte lane of each plane slot, slot 0 in the lowest bits: 2, 1, 0, 3
   localparam logic [7:0] LANE_ORDER = {2'd3, 2'd0, 2'd1, 2'd2};

   typedef longint unsigned count_type;

   typedef enum logic [1:0] {ST_SKIP, ST_HEADER, ST_LITERAL, ST_RUN} parse_state_type;
   typedef enum logic [1:0] {ROW_CSR, ROW_BYTE, ROW_TYPED} row_kind_type;

   typedef struct packed {
      logic [23:0] pixel_index;
      logic [1:0]  byte_lane;
      logic [7:0]  pixel_value;
      logic [7:0]  run_length;
      logic        run_clipped;
      logic        image_end;
   } run_write_type;

   typedef struct {
      row_kind_type            kind;
      pbpd_pkg::csr_index_type reg_index;
      logic [12:0]             value;
      bit                      has_write;
      run_write_type           write;
   } table_row_type;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [7:0]              req_tdata  = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [47:0]             rsp_tdata;
   logic                    rsp_tuser;
   logic                    rsp_tlast;
   logic                    csr_we     = 1'b0;
   pbpd_pkg::csr_index_type csr_index  = pbpd_pkg::CSR_IMAGE_WIDTH;
   logic [12:0]             csr_data   = '0;

   // Decoder copy: settings and parse state
   int unsigned     cfg_width, cfg_height, cfg_channels;
   bit              cfg_compressed;
   parse_state_type dec_state;
   int unsigned     skip_left, plane_slot, literal_left;
   count_type       plane_pos;
   bit              decode_done;

   run_write_type run_writes_due[$];
   logic [7:0]    stream_bytes[$];
   int unsigned   mismatches = 0;

   int unsigned sender_idle_pct    = 0;
   int unsigned receiver_stall_pct = 0;
   int unsigned hold_epoch = 0, hold_seen = 0, hold_left = 0;

   packbits_plane_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   function automatic int unsigned clamp_to(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic count_type plane_total();
      return count_type'(clamp_to(cfg_width, MAX_DIM)) *
             count_type'(clamp_to(cfg_height, MAX_DIM));
   endfunction

   // First slot at or after from whose lane is below the channel count; 4 when none
   function automatic int unsigned next_slot(int unsigned from);
      int unsigned ch;
      ch = clamp_to(cfg_channels, MAX_CH);
      while (from < 4 && LANE_ORDER[2*from +: 2] >= ch) from++;
      return from;
   endfunction

   function automatic void restart_decode();
      dec_state    = cfg_compressed ? ST_SKIP : ST_HEADER;
      skip_left    = clamp_to(cfg_height, MAX_DIM) * clamp_to(cfg_channels, MAX_CH) * 2;
      plane_slot   = next_slot(0);
      plane_pos    = 0;
      literal_left = 0;
      decode_done  = (plane_slot >= 4);
   endfunction

   function automatic void advance_plane();
      plane_slot   = next_slot(plane_slot + 1);
      plane_pos    = 0;
      literal_left = 0;
      dec_state    = ST_HEADER;
      if (plane_slot >= 4) decode_done = 1'b1;
   endfunction

   function automatic run_write_type make_write(logic [7:0] value, count_type len, bit clipped,
                                                bit ends);
      run_write_type w;
      w.pixel_index = plane_pos[23:0];
      w.byte_lane   = LANE_ORDER[2*(plane_slot & 3) +: 2];
      w.pixel_value = value;
      w.run_length  = len[7:0];
      w.run_clipped = clipped;
      w.image_end   = ends;
      return w;
   endfunction

   // Advance the decoder copy by one stream byte; produced marks a run write
   function automatic void decode_byte(input logic [7:0] b, output bit produced,
                                       output run_write_type w);
      count_type total, room, len;
      bit        last_plane, clip;
      total      = plane_total();
      last_plane = (next_slot(plane_slot + 1) >= 4);
      produced   = 1'b0;
      w          = '0;
      clip       = 1'b0;
      if (decode_done || plane_slot >= 4) return;
      if (!cfg_compressed) begin
         w        = make_write(b, 1, 1'b0, (plane_pos + 1 >= total) && last_plane);
         produced = 1'b1;
         plane_pos++;
         if (plane_pos >= total) advance_plane();
         return;
      end
      case (dec_state)
         ST_SKIP: begin
            if (skip_left > 1) begin
               skip_left--;
            end else begin
               skip_left = 0;
               dec_state = ST_HEADER;
            end
         end
         ST_HEADER: begin
            if (b < pbpd_pkg::HDR_NOP) begin
               literal_left = b + 1;
               dec_state    = ST_LITERAL;
            end else if (b > pbpd_pkg::HDR_NOP) begin
               literal_left = (b ^ pbpd_pkg::RUN_XOR) + 2;
               dec_state    = ST_RUN;
            end
         end
         ST_LITERAL: begin
            // past the plane end the rest of the literal is swallowed
            if (plane_pos < total) begin
               w = make_write(b, 1, (plane_pos + 1 >= total) && literal_left > 1,
                              (plane_pos + 1 >= total) && last_plane);
               produced = 1'b1;
               plane_pos++;
            end
            if (literal_left > 0) literal_left--;
            if (literal_left == 0) begin
               if (plane_pos >= total) advance_plane();
               else dec_state = ST_HEADER;
            end
         end
         default: begin
            if (literal_left == 0 || plane_pos >= total) begin
               advance_plane();
               return;
            end
            // cut the run at the plane end
            room = total - plane_pos;
            len  = literal_left;
            if (len > room) begin
               len  = room;
               clip = 1'b1;
            end
            w = make_write(b, len, clip, (plane_pos + len >= total) && last_plane);
            produced     = 1'b1;
            plane_pos    = plane_pos + len;
            literal_left = 0;
            if (plane_pos >= total) advance_plane();
            else dec_state = ST_HEADER;
         end
      endcase
   endfunction

   // Packet length that mostly fits the room left in the plane
   function automatic int unsigned packet_length(int unsigned lo);
      count_type   room;
      int unsigned cap;
      room = plane_total() - plane_pos;
      cap  = (room > 126) ? 128 : 32'(room) + 2;
      if ($urandom_range(9) == 0) cap = 128;
      return $urandom_range(cap, lo);
   endfunction

   // Queue the next packet: well-formed header with payload, a no-op header, or a noise byte
   function automatic void plan_packet();
      int unsigned pick, len;
      if (dec_state != ST_HEADER || $urandom_range(19) == 0) begin
         stream_bytes.push_back(8'($urandom));
         return;
      end
      pick = $urandom_range(99);
      if (pick < 5) begin
         stream_bytes.push_back(pbpd_pkg::HDR_NOP);
      // large planes get runs only, so they fill within a short stream
      end else if (pick < 5 + ((plane_total() > 1024) ? 95 :
                               (plane_total() > 64) ? 80 : 30)) begin
         len = packet_length(2);
         stream_bytes.push_back(8'(len - 2) ^ pbpd_pkg::RUN_XOR);
         stream_bytes.push_back(8'($urandom));
      end else begin
         len = packet_length(1);
         stream_bytes.push_back(8'(len - 1));
         repeat (len) stream_bytes.push_back(8'($urandom));
      end
   endfunction

   function automatic table_row_type make_row(row_kind_type kind,
                                              pbpd_pkg::csr_index_type idx,
                                              logic [12:0] value, bit has_write,
                                              run_write_type write);
      table_row_type r;
      r.kind      = kind;
      r.reg_index = idx;
      r.value     = value;
      r.has_write = has_write;
      r.write     = write;
      return r;
   endfunction

   function automatic table_row_type csr_row(pbpd_pkg::csr_index_type idx, logic [12:0] value);
      return make_row(ROW_CSR, idx, value, 1'b0, '0);
   endfunction

   // Byte checked against the decoder copy
   function automatic table_row_type byte_row(logic [7:0] b);
      return make_row(ROW_BYTE, pbpd_pkg::CSR_IMAGE_WIDTH, b, 1'b0, '0);
   endfunction

   // Byte that gives no run write
   function automatic table_row_type quiet_row(logic [7:0] b);
      return make_row(ROW_TYPED, pbpd_pkg::CSR_IMAGE_WIDTH, b, 1'b0, '0);
   endfunction

   // Byte with its run write typed in
   function automatic table_row_type write_row(logic [7:0] b, int unsigned idx,
                                               logic [1:0] lane, logic [7:0] len, bit clip,
                                               bit last);
      run_write_type w;
      w.pixel_index = idx[23:0];
      w.byte_lane   = lane;
      w.pixel_value = b;
      w.run_length  = len;
      w.run_clipped = clip;
      w.image_end   = last;
      return make_row(ROW_TYPED, pbpd_pkg::CSR_IMAGE_WIDTH, b, 1'b1, w);
   endfunction

   // Offer one byte after random idle cycles; return at the edge of its transfer
   task automatic offer_byte(input logic [7:0] b);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic feed_byte(input logic [7:0] b);
      bit            got;
      run_write_type expected;
      decode_byte(b, got, expected);
      if (got) run_writes_due.push_back(expected);
      offer_byte(b);
   endtask

   // Drive one register write; csr_we stays high for a following write
   task automatic write_register(input pbpd_pkg::csr_index_type idx, input logic [12:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      case (idx)
         pbpd_pkg::CSR_IMAGE_WIDTH:   cfg_width      = value;
         pbpd_pkg::CSR_IMAGE_HEIGHT:  cfg_height     = value;
         pbpd_pkg::CSR_CHANNEL_COUNT: cfg_channels   = value[4:0];
         default:                     cfg_compressed = value[0];
      endcase
      restart_decode();
      @(posedge clock);
   endtask

   // Drop the write enable and let the derived plane size settle
   task automatic close_registers();
      csr_we <= 1'b0;
      repeat (2) @(posedge clock);
   endtask

   // Stop offering, wait out every due run write and the bytes still in flight
   task automatic drain_block();
      req_tvalid <= 1'b0;
      while (run_writes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Result side: check each transfer, then pick tready for the next cycle
   always @(posedge clock) begin : rsp_side
      run_write_type due, seen;
      if (!reset && rsp_tvalid && rsp_tready) begin
         // tdata: pixel_index[23:0], byte_lane[25:24], pixel_value[33:26], run_length[41:34]
         seen.pixel_index = rsp_tdata[23:0];
         seen.byte_lane   = rsp_tdata[25:24];
         seen.pixel_value = rsp_tdata[33:26];
         seen.run_length  = rsp_tdata[41:34];
         seen.run_clipped = rsp_tuser;
         seen.image_end   = rsp_tlast;
         if (run_writes_due.size() == 0) begin
            $error("run write with none due: pixel_index %0d byte_lane %0d",
                   seen.pixel_index, seen.byte_lane);
            mismatches++;
         end else begin
            due = run_writes_due.pop_front();
            if (seen.pixel_index !== due.pixel_index) begin
               $error("pixel_index: expected %0d, actual %0d", due.pixel_index, seen.pixel_index);
               mismatches++;
            end
            if (seen.byte_lane !== due.byte_lane) begin
               $error("byte_lane: expected %0d, actual %0d", due.byte_lane, seen.byte_lane);
               mismatches++;
            end
            if (seen.pixel_value !== due.pixel_value) begin
               $error("pixel_value: expected %0d, actual %0d", due.pixel_value, seen.pixel_value);
               mismatches++;
            end
            if (seen.run_length !== due.run_length) begin
               $error("run_length: expected %0d, actual %0d", due.run_length, seen.run_length);
               mismatches++;
            end
            if (seen.run_clipped !== due.run_clipped) begin
               $error("run_clipped: expected %0d, actual %0d", due.run_clipped, seen.run_clipped);
               mismatches++;
            end
            if (seen.image_end !== due.image_end) begin
               $error("image_end: expected %0d, actual %0d", due.image_end, seen.image_end);
               mismatches++;
            end
         end
      end
      // hold off for a long stretch on request, else stall at random
      if (hold_epoch != hold_seen) begin
         hold_seen  <= hold_epoch;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   initial begin : stimulus
      table_row_type rows[$];
      table_row_type row;
      bit            got, csr_open;
      run_write_type discard;
      int unsigned   phase_no, counted, phase_items, cut_at, r;
      int unsigned   w_cfg, h_cfg, ch_cfg, c_cfg;

      cfg_width      = pbpd_pkg::RESET_WIDTH;
      cfg_height     = pbpd_pkg::RESET_HEIGHT;
      cfg_channels   = pbpd_pkg::RESET_CHANNELS;
      cfg_compressed = pbpd_pkg::RESET_COMPRESSED;
      restart_decode();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: six count bytes, then lanes 2, 1, 0 of one pixel each
      rows.push_back(quiet_row(8'h00));
      rows.push_back(quiet_row(8'hFF));
      rows.push_back(quiet_row(8'h55));
      rows.push_back(quiet_row(8'hAA));
      rows.push_back(quiet_row(8'h01));
      rows.push_back(quiet_row(8'h80));
      rows.push_back(quiet_row(pbpd_pkg::HDR_NOP));      // no-op header
      rows.push_back(quiet_row(8'h00));                  // literal of one
      rows.push_back(write_row(8'hFF, 0, 2'd2, 8'd1, 1'b0, 1'b0));
      rows.push_back(quiet_row(8'hFF));                  // run of two
      rows.push_back(write_row(8'h00, 0, 2'd1, 8'd1, 1'b1, 1'b0));
      rows.push_back(quiet_row(8'h01));                  // literal of two
      rows.push_back(write_row(8'hA5, 0, 2'd0, 8'd1, 1'b1, 1'b1));
      rows.push_back(byte_row(8'h5A));                   // literal tail past plane end
      rows.push_back(byte_row(8'h33));                   // after the image
      // Raw planes with width and channel count clamped up to one
      rows.push_back(csr_row(pbpd_pkg::CSR_COMPRESSED, 13'd0));
      rows.push_back(csr_row(pbpd_pkg::CSR_CHANNEL_COUNT, 13'd0));
      rows.push_back(csr_row(pbpd_pkg::CSR_IMAGE_WIDTH, 13'd0));
      rows.push_back(csr_row(pbpd_pkg::CSR_IMAGE_HEIGHT, 13'd2));
      rows.push_back(write_row(8'h00, 0, 2'd0, 8'd1, 1'b0, 1'b0));
      rows.push_back(write_row(8'hFF, 1, 2'd0, 8'd1, 1'b0, 1'b1));
      rows.push_back(byte_row(8'h80));
      // Longest run, then a run cut at the plane end
      rows.push_back(csr_row(pbpd_pkg::CSR_COMPRESSED, 13'd1));
      rows.push_back(csr_row(pbpd_pkg::CSR_CHANNEL_COUNT, 13'd1));
      rows.push_back(csr_row(pbpd_pkg::CSR_IMAGE_WIDTH, 13'd130));
      rows.push_back(csr_row(pbpd_pkg::CSR_IMAGE_HEIGHT, 13'd1));
      rows.push_back(byte_row(8'h12));
      rows.push_back(byte_row(8'hED));
      rows.push_back(quiet_row(8'h81));
      rows.push_back(write_row(8'h77, 0, 2'd0, 8'd128, 1'b0, 1'b0));
      rows.push_back(quiet_row(8'h81));
      rows.push_back(write_row(8'h11, 128, 2'd0, 8'd2, 1'b1, 1'b1));

      // Walk the table with light idling on both sides
      sender_idle_pct    = 6;
      receiver_stall_pct = 6;
      csr_open           = 1'b0;
      foreach (rows[i]) begin
         row = rows[i];
         if (row.kind == ROW_CSR) begin
            if (!csr_open) drain_block();
            write_register(row.reg_index, row.value);
            csr_open = 1'b1;
         end else begin
            if (csr_open) close_registers();
            csr_open = 1'b0;
            if (row.kind == ROW_TYPED) begin
               decode_byte(row.value[7:0], got, discard);
               if (row.has_write) run_writes_due.push_back(row.write);
               offer_byte(row.value[7:0]);
            end else begin
               feed_byte(row.value[7:0]);
            end
         end
      end

      // Random phases: extreme settings first, then small planes until enough bytes
      counted = 0;
      for (phase_no = 0; phase_no < EXTREME_PHASES || counted < RANDOM_ITEMS; phase_no++) begin
         case (phase_no)
            0: begin w_cfg = 8191; h_cfg = 1;    ch_cfg = 1;  c_cfg = 1; end
            1: begin w_cfg = 1;    h_cfg = 8191; ch_cfg = 1;  c_cfg = 1; end
            2: begin w_cfg = 4;    h_cfg = 4;    ch_cfg = 24; c_cfg = 0; end
            3: begin w_cfg = 3;    h_cfg = 1;    ch_cfg = 31; c_cfg = 1; end
            4: begin w_cfg = 0;    h_cfg = 0;    ch_cfg = 0;  c_cfg = 0; end
            default: begin
               w_cfg  = ($urandom_range(9) == 0) ? 0 : $urandom_range(6, 1);
               h_cfg  = ($urandom_range(9) == 0) ? 0 : $urandom_range(3, 1);
               r      = $urandom_range(99);
               ch_cfg = (r < 70) ? $urandom_range(5, 1) : (r < 85) ? 0 : $urandom_range(31, 6);
               c_cfg  = ($urandom_range(9) < 8);
            end
         endcase
         drain_block();
         case (phase_no % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 56; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 56; end
            default: begin sender_idle_pct = 6; receiver_stall_pct = 6; end
         endcase
         write_register(pbpd_pkg::CSR_IMAGE_WIDTH, 13'(w_cfg));
         write_register(pbpd_pkg::CSR_IMAGE_HEIGHT, 13'(h_cfg));
         write_register(pbpd_pkg::CSR_CHANNEL_COUNT, 13'(ch_cfg));
         write_register(pbpd_pkg::CSR_COMPRESSED, 13'(c_cfg));
         close_registers();
         // back up the result side while raw pixels keep coming
         if (phase_no == HOLD_PHASE) hold_epoch <= hold_epoch + 1;
         // stop the tall image inside its skip, and now and then cut a random phase short
         if (phase_no == LONG_SKIP_PHASE) begin
            cut_at = LONG_SKIP_BYTES;
         end else begin
            cut_at = (phase_no >= EXTREME_PHASES && $urandom_range(9) == 0) ?
                     $urandom_range(24, 1) : 0;
         end
         phase_items = 0;
         stream_bytes.delete();
         while (!decode_done && (cut_at == 0 || phase_items < cut_at)) begin
            if (stream_bytes.size() == 0) plan_packet();
            feed_byte(stream_bytes.pop_front());
            phase_items++;
            counted++;
         end
         repeat ($urandom_range(3, 0)) feed_byte(8'($urandom));
      end

      drain_block();
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("Test completed with failures");
      $finish;
   end

endmodule
